>>> src/urx_pkg.sv
`default_nettype none

package urx_pkg;

  typedef enum logic [1:0] {
    OP_BUS_READ  = 2'd0,
    OP_BUS_WRITE = 2'd1,
    OP_RX_BYTE   = 2'd2,
    OP_NONE      = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_DATA    = 2'd0,
    REG_STATUS  = 2'd1,
    REG_CONTROL = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_sel_e;

  // Status bit positions.
  localparam int unsigned StRxReady  = 0;
  localparam int unsigned StTxEmpty  = 1;
  localparam int unsigned StRxFull   = 2;
  localparam int unsigned StOverflow = 3;

  // Control bit positions.
  localparam int unsigned CtRxEn  = 0;
  localparam int unsigned CtTxEn  = 1;
  localparam int unsigned CtReset = 7;

  localparam logic [3:0] StatusReset  = 4'b0010;
  localparam logic [7:0] ControlReset = 8'h00;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic near_full;
    logic last;
  } ring_stat_t;

endpackage

`default_nettype wire

>>> src/urx_if.sv
`default_nettype none

interface urx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] reg_select;
  logic [7:0] write_value;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output reg_select, output write_value,
                  output rx_byte, input ready);
  modport sink (input valid, input opcode, input reg_select, input write_value,
                input rx_byte, output ready);
endinterface

interface urx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_level;
  logic       tx_valid;
  logic [7:0] tx_byte;

  modport source (output valid, output read_data, output irq_level, output tx_valid,
                  output tx_byte, input ready);
  modport sink (input valid, input read_data, input irq_level, input tx_valid,
                input tx_byte, output ready);
endinterface

`default_nettype wire

>>> src/urx_ring.sv
`default_nettype none

module urx_ring #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  urx_pkg::ring_ctrl_t ctrl_i,
  input  wire  [7:0]          push_data_i,
  output urx_pkg::ring_stat_t stat_o,
  output logic [7:0]          rd_data_o
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [AW-1:0] head_next, tail_next;
  logic [AW:0]   used_after_push;
  logic [7:0]    rd_q;

  assign head_next = (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign tail_next = (tail_q == AW'(FIFO_DEPTH - 1)) ? '0 : tail_q + AW'(1);

  // Fill level the ring would have once the pending byte is stored.
  always_comb begin
    if (tail_next >= head_q) begin
      used_after_push = {1'b0, tail_next} - {1'b0, head_q};
    end else begin
      used_after_push = {1'b0, tail_next} + (AW+1)'(FIFO_DEPTH) - {1'b0, head_q};
    end
  end

  assign stat_o.empty     = (head_q == tail_q);
  assign stat_o.full      = (tail_next == head_q);
  assign stat_o.near_full = (used_after_push > (AW+1)'(FIFO_DEPTH - 4));
  // Exactly one byte is held, so a pop leaves the ring empty.
  assign stat_o.last      = (head_next == tail_q);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.clear) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (ctrl_i.pop) begin
        head_d = head_next;
      end
      if (ctrl_i.push) begin
        tail_d = tail_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // A pop reads at head while a push writes at tail; the two never coincide
  // because a pop needs a non-empty ring.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      rd_q <= mem[head_q];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

>>> src/uart_rx_fifo_register_device.sv
// UART register block with a receive ring buffer.
// Items arrive on in_i (valid/ready); each is a bus read, a bus write, a
// received serial byte or a no-op. Every item yields exactly one result
// beat on out_o, carrying read data, the interrupt level after the item,
// and the transmit strobe and byte of a data write.
// The result of an item is registered at acceptance and offered from the
// next cycle. One item per cycle is sustained while the receiver takes each
// result; the registers and ring pointers are updated at acceptance and the
// ring memory is read into the ring's read register, which feeds out_o.
// When the receiver stalls, the result stays on out_o and in_i.ready drops
// until the result beat is taken, so no item is lost.
// Reset empties the ring, sets status to tx-empty only and clears control.
// The ring contents need no clearing; only stored entries are ever read.
// The ring holds at most FIFO_DEPTH-1 bytes.
`default_nettype none

module uart_rx_fifo_register_device #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input wire         clk_i,
  input wire         rst_ni,
  urx_in_if.sink     in_i,
  urx_out_if.source  out_o
);

  logic                accept;
  logic [3:0]          status_q, status_d;
  logic [7:0]          control_q, control_d;
  urx_pkg::ring_ctrl_t ring_ctrl;
  urx_pkg::ring_stat_t ring_stat;
  logic [7:0]          ring_rd;
  logic [7:0]          rdata_d;
  logic                tx_valid_d;
  logic [7:0]          tx_byte_d;
  logic                irq_d;

  logic                out_valid_q;
  logic                use_mem_q;
  logic [7:0]          rdata_q;
  logic                irq_q;
  logic                tx_valid_q;
  logic [7:0]          tx_byte_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    status_d        = status_q;
    control_d       = control_q;
    ring_ctrl.push  = 1'b0;
    ring_ctrl.pop   = 1'b0;
    ring_ctrl.clear = 1'b0;
    rdata_d         = '0;
    tx_valid_d      = 1'b0;
    tx_byte_d       = '0;
    case (urx_pkg::opcode_e'(in_i.opcode))
      urx_pkg::OP_BUS_READ: begin
        case (urx_pkg::reg_sel_e'(in_i.reg_select))
          urx_pkg::REG_DATA: begin
            if (!ring_stat.empty) begin
              ring_ctrl.pop = accept;
              // Taking the last byte empties the ring.
              if (ring_stat.last) begin
                status_d[urx_pkg::StRxReady] = 1'b0;
              end
              status_d[urx_pkg::StRxFull] = 1'b0;
            end
          end
          urx_pkg::REG_STATUS:  rdata_d = {4'b0000, status_q};
          urx_pkg::REG_CONTROL: rdata_d = control_q;
          default:              rdata_d = '0;
        endcase
      end
      urx_pkg::OP_BUS_WRITE: begin
        case (urx_pkg::reg_sel_e'(in_i.reg_select))
          urx_pkg::REG_DATA: begin
            tx_valid_d                   = 1'b1;
            tx_byte_d                    = in_i.write_value;
            status_d[urx_pkg::StTxEmpty] = 1'b1;
          end
          urx_pkg::REG_CONTROL: begin
            control_d = in_i.write_value;
            if (in_i.write_value[urx_pkg::CtReset]) begin
              ring_ctrl.clear             = accept;
              status_d                    = urx_pkg::StatusReset;
              control_d[urx_pkg::CtReset] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      urx_pkg::OP_RX_BYTE: begin
        if (ring_stat.full) begin
          status_d[urx_pkg::StOverflow] = 1'b1;
        end else begin
          ring_ctrl.push               = accept;
          status_d[urx_pkg::StRxReady] = 1'b1;
          if (ring_stat.near_full) begin
            status_d[urx_pkg::StRxFull] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    irq_d = (control_d[urx_pkg::CtRxEn] && status_d[urx_pkg::StRxReady]) ||
            (control_d[urx_pkg::CtTxEn] && status_d[urx_pkg::StTxEmpty]);
  end

  urx_ring #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ring_ctrl),
    .push_data_i (in_i.rx_byte),
    .stat_o      (ring_stat),
    .rd_data_o   (ring_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= urx_pkg::StatusReset;
      control_q   <= urx_pkg::ControlReset;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        status_q  <= status_d;
        control_q <= control_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      use_mem_q  <= ring_ctrl.pop;
      rdata_q    <= rdata_d;
      irq_q      <= irq_d;
      tx_valid_q <= tx_valid_d;
      tx_byte_q  <= tx_byte_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = use_mem_q ? ring_rd : rdata_q;
  assign out_o.irq_level = irq_q;
  assign out_o.tx_valid  = tx_valid_q;
  assign out_o.tx_byte   = tx_byte_q;

endmodule

`default_nettype wire
